@@ rtl/rwpm_pkg.sv @@
// shared types and constants for the rating window pair matcher
// used by rwpm_cell and rating_window_pair_matcher_top; depends on nothing
package rwpm_pkg;

   localparam int ENTRIES  = 16;
   localparam int ID_BITS  = 16;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int RATING_W = 12;
   localparam int TIME_W   = 32;

   // input selector codes, anything else is a tick
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;

   // register indexes
   localparam logic REG_RATING_RANGE = 1'b0;
   localparam logic REG_TIMEOUT      = 1'b1;

   typedef enum logic [2:0] {
      KIND_MATCH     = 3'd0,
      KIND_TIMED_OUT = 3'd1,
      KIND_ADDED     = 3'd2,
      KIND_DUPLICATE = 3'd3,
      KIND_FULL      = 3'd4,
      KIND_REMOVED   = 3'd5,
      KIND_NOT_FOUND = 3'd6,
      KIND_TICK_DONE = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_SHIFT1,
      CELL_SHIFT2
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_PAIR,
      ST_EXPIRE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [RATING_W-1:0] rating;
      logic [TIME_W-1:0]   join_time;
   } slot_type;

   // values broadcast to every cell
   typedef struct packed {
      logic [ID_BITS-1:0]  probe_id;
      logic [RATING_W-1:0] anchor_rating;
      logic [RATING_W-1:0] rating_range;
      logic [TIME_W-1:0]   now;
      logic [TIME_W-1:0]   timeout;
   } cell_key_type;

   typedef struct packed {
      logic id_match;
      logic rate_match;
      logic expired;
   } cell_flags_type;

endpackage

@@ rtl/rating_window_pair_matcher_top.sv @@
// rating window pair matcher: table as a chain of cells plus sequencer
// depends on rwpm_pkg and rwpm_cell
// enqueue/dequeue: word latched on acceptance, result emitted from ST_SINGLE; no new word until ST_IDLE.
// tick: each anchor is scanned in turn and a match emits both ids and removes both slots, then each
//   expired entry is emitted and removed, then a done word with tlast closes the tick.
// output register stalls the sequencer while a result waits; reset is synchronous,
//   empties the table and restores register defaults (range 100, timeout 30000).
module rating_window_pair_matcher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // player_id[15:0], rating[27:16], now_ms[59:28], zero
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // first_id[15:0], second_id[31:16], waiting_count[36:32], zero
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int N = rwpm_pkg::ENTRIES;

   // configuration registers
   logic [rwpm_pkg::RATING_W-1:0] range_ff;
   logic [rwpm_pkg::TIME_W-1:0]   timeout_ff;
   logic                          cfg_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff   <= 12'd100;
         timeout_ff <= 32'd30000;
      end else if (cfg_wr) begin
         if (csr_paddr[2] == rwpm_pkg::REG_RATING_RANGE) begin
            range_ff <= csr_pwdata[rwpm_pkg::RATING_W-1:0];
         end else begin
            timeout_ff <= csr_pwdata;
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == rwpm_pkg::REG_TIMEOUT) ? timeout_ff : 32'(range_ff);

   // sequencer state and latched input word
   rwpm_pkg::state_type            state_ff, state_in;
   logic [1:0]                     op_ff;
   logic [rwpm_pkg::ID_BITS-1:0]   id_ff;
   logic [rwpm_pkg::RATING_W-1:0]  rating_ff;
   logic [rwpm_pkg::TIME_W-1:0]    now_ff;
   logic [rwpm_pkg::IDX_W-1:0]     anchor_ff, anchor_in;
   logic [rwpm_pkg::CNT_W-1:0]     count_ff, count_in;

   // output register
   logic                      out_valid_ff;
   rwpm_pkg::kind_type        out_kind_ff;
   logic [15:0]               out_first_ff, out_second_ff;
   logic [4:0]                out_count_ff;
   logic                      out_last_ff;
   logic                      out_free;

   // cell row
   rwpm_pkg::slot_type        slots [N];
   rwpm_pkg::slot_type        next1 [N];
   rwpm_pkg::slot_type        next2 [N];
   rwpm_pkg::cell_flags_type  flags [N];
   rwpm_pkg::cell_cmd_type    cmds  [N];
   rwpm_pkg::cell_key_type    key;
   rwpm_pkg::slot_type        load_data;

   logic [N-1:0]               id_hit, rate_hit, exp_hit;
   logic [rwpm_pkg::IDX_W-1:0] id_idx, rate_idx, exp_idx;

   // emission and table edit
   logic                       emit;
   rwpm_pkg::kind_type         emit_kind;
   logic [15:0]                emit_first, emit_second;
   logic                       emit_last;
   logic                       do_load, do_rm1, do_rm2;
   logic [rwpm_pkg::IDX_W-1:0] rm_a, rm_b;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == rwpm_pkg::ST_IDLE);

   // broadcast key and new slot word
   always_comb begin
      key.probe_id      = id_ff;
      key.anchor_rating = slots[anchor_ff].rating;
      key.rating_range  = range_ff;
      key.now           = now_ff;
      key.timeout       = timeout_ff;
      load_data.id        = id_ff;
      load_data.rating    = rating_ff;
      load_data.join_time = now_ff;
   end

   // neighbor links, links that would run past the tail carry the cell's own slot
   always_comb begin
      for (int c = 0; c < N; c++) begin
         next1[c] = (c + 1 < N) ? slots[(c + 1) % N] : slots[c];
         next2[c] = (c + 2 < N) ? slots[(c + 2) % N] : slots[c];
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      rwpm_cell u_cell (
         .clock     (clock),
         .cmd       (cmds[g]),
         .load_data (load_data),
         .next1     (next1[g]),
         .next2     (next2[g]),
         .key       (key),
         .slot      (slots[g]),
         .flags     (flags[g])
      );
   end

   // gate flags by occupancy (rate hits also to cells past the anchor) and find the first hit of each kind
   always_comb begin
      id_idx   = '0;
      rate_idx = '0;
      exp_idx  = '0;
      for (int c = 0; c < N; c++) begin
         id_hit[c]   = (rwpm_pkg::CNT_W'(c) < count_ff) && flags[c].id_match;
         rate_hit[c] = (rwpm_pkg::CNT_W'(c) < count_ff) && flags[c].rate_match
                       && (rwpm_pkg::IDX_W'(c) > anchor_ff);
         exp_hit[c]  = (rwpm_pkg::CNT_W'(c) < count_ff) && flags[c].expired;
      end
      for (int c = N - 1; c >= 0; c--) begin
         if (id_hit[c]) id_idx = rwpm_pkg::IDX_W'(c);
         if (rate_hit[c]) rate_idx = rwpm_pkg::IDX_W'(c);
         if (exp_hit[c]) exp_idx = rwpm_pkg::IDX_W'(c);
      end
   end

   // next state, emission and table edit
   always_comb begin
      state_in    = state_ff;
      anchor_in   = anchor_ff;
      count_in    = count_ff;
      emit        = 1'b0;
      emit_kind   = rwpm_pkg::KIND_TICK_DONE;
      emit_first  = '0;
      emit_second = '0;
      emit_last   = 1'b0;
      do_load     = 1'b0;
      do_rm1      = 1'b0;
      do_rm2      = 1'b0;
      rm_a        = '0;
      rm_b        = '0;
      case (state_ff)
         rwpm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               anchor_in = '0;
               if (req_tuser == rwpm_pkg::OP_ENQUEUE || req_tuser == rwpm_pkg::OP_DEQUEUE) begin
                  state_in = rwpm_pkg::ST_SINGLE;
               end else begin
                  state_in = rwpm_pkg::ST_PAIR;
               end
            end
         end
         rwpm_pkg::ST_SINGLE: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_last  = 1'b1;
               emit_first = 16'(id_ff);
               state_in   = rwpm_pkg::ST_IDLE;
               if (op_ff == rwpm_pkg::OP_ENQUEUE) begin
                  if (|id_hit) begin
                     emit_kind = rwpm_pkg::KIND_DUPLICATE;
                  end else if (count_ff == rwpm_pkg::CNT_W'(N)) begin
                     emit_kind = rwpm_pkg::KIND_FULL;
                  end else begin
                     emit_kind = rwpm_pkg::KIND_ADDED;
                     do_load   = 1'b1;
                     count_in  = count_ff + 1'b1;
                  end
               end else begin
                  if (|id_hit) begin
                     emit_kind = rwpm_pkg::KIND_REMOVED;
                     do_rm1    = 1'b1;
                     rm_a      = id_idx;
                     count_in  = count_ff - 1'b1;
                  end else begin
                     emit_kind = rwpm_pkg::KIND_NOT_FOUND;
                  end
               end
            end
         end
         rwpm_pkg::ST_PAIR: begin
            if (rwpm_pkg::CNT_W'(anchor_ff) + 1'b1 >= count_ff) begin
               state_in = rwpm_pkg::ST_EXPIRE;
            end else if (|rate_hit) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_kind   = rwpm_pkg::KIND_MATCH;
                  emit_first  = 16'(slots[anchor_ff].id);
                  emit_second = 16'(slots[rate_idx].id);
                  do_rm2      = 1'b1;
                  rm_a        = anchor_ff;
                  rm_b        = rate_idx;
                  count_in    = count_ff - 2'd2;
               end
            end else begin
               anchor_in = anchor_ff + 1'b1;
            end
         end
         rwpm_pkg::ST_EXPIRE: begin
            if (|exp_hit) begin
               if (out_free) begin
                  emit       = 1'b1;
                  emit_kind  = rwpm_pkg::KIND_TIMED_OUT;
                  emit_first = 16'(slots[exp_idx].id);
                  do_rm1     = 1'b1;
                  rm_a       = exp_idx;
                  count_in   = count_ff - 1'b1;
               end
            end else begin
               state_in = rwpm_pkg::ST_DONE;
            end
         end
         rwpm_pkg::ST_DONE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = rwpm_pkg::KIND_TICK_DONE;
               emit_last = 1'b1;
               state_in  = rwpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rwpm_pkg::ST_IDLE;
         end
      endcase
   end

   // per-cell commands from the table edit
   always_comb begin
      for (int c = 0; c < N; c++) begin
         cmds[c] = rwpm_pkg::CELL_HOLD;
         if (do_load && rwpm_pkg::CNT_W'(c) == count_ff) begin
            cmds[c] = rwpm_pkg::CELL_LOAD;
         end else if (do_rm1 && rwpm_pkg::IDX_W'(c) >= rm_a) begin
            cmds[c] = rwpm_pkg::CELL_SHIFT1;
         end else if (do_rm2) begin
            if (rwpm_pkg::IDX_W'(c) >= rm_b - 1'b1) begin
               cmds[c] = rwpm_pkg::CELL_SHIFT2;
            end else if (rwpm_pkg::IDX_W'(c) >= rm_a) begin
               cmds[c] = rwpm_pkg::CELL_SHIFT1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rwpm_pkg::ST_IDLE;
         count_ff     <= '0;
         anchor_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         anchor_ff <= anchor_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff     <= req_tuser;
         id_ff     <= req_tdata[rwpm_pkg::ID_BITS-1:0];
         rating_ff <= req_tdata[27:16];
         now_ff    <= req_tdata[59:28];
      end
      if (emit) begin
         out_kind_ff   <= emit_kind;
         out_first_ff  <= emit_first;
         out_second_ff <= emit_second;
         out_count_ff  <= 5'(count_in);
         out_last_ff   <= emit_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {3'b000, out_count_ff, out_second_ff, out_first_ff};

endmodule

@@ rtl/rwpm_cell.sv @@
// one slot of the arrival-ordered table with its local compares
// depends on rwpm_pkg
module rwpm_cell (
   input  logic                   clock,
   input  rwpm_pkg::cell_cmd_type cmd,
   input  rwpm_pkg::slot_type     load_data,
   input  rwpm_pkg::slot_type     next1,
   input  rwpm_pkg::slot_type     next2,
   input  rwpm_pkg::cell_key_type key,
   output rwpm_pkg::slot_type     slot,
   output rwpm_pkg::cell_flags_type flags
);

   rwpm_pkg::slot_type slot_ff;
   rwpm_pkg::slot_type slot_in;
   logic [rwpm_pkg::RATING_W-1:0] diff;
   logic [rwpm_pkg::TIME_W-1:0]   waited;

   // slot update: hold, take new word, or shift down by one or two
   always_comb begin
      case (cmd)
         rwpm_pkg::CELL_LOAD:   slot_in = load_data;
         rwpm_pkg::CELL_SHIFT1: slot_in = next1;
         rwpm_pkg::CELL_SHIFT2: slot_in = next2;
         default:               slot_in = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // local compares
   always_comb begin
      if (slot_ff.rating >= key.anchor_rating) begin
         diff = slot_ff.rating - key.anchor_rating;
      end else begin
         diff = key.anchor_rating - slot_ff.rating;
      end
      waited           = key.now - slot_ff.join_time;
      flags.id_match   = (slot_ff.id == key.probe_id);
      flags.rate_match = (diff <= key.rating_range);
      flags.expired    = (waited >= key.timeout);
   end

   assign slot = slot_ff;

endmodule
